### hdl/enveloped_sine_note_synth_macros.svh
// Assertion macros shared by the note synthesizer RTL
`ifndef ENVELOPED_SINE_NOTE_SYNTH_MACROS_SVH
`define ENVELOPED_SINE_NOTE_SYNTH_MACROS_SVH

// clocked property, off while reset is asserted
`define ESN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define ESN_NEVER(lbl, cond, msg) \
  `ESN_ASSERT(lbl, !(cond), msg)

`endif

### hdl/esn_pkg.sv
// Types, constants and helper functions of the note synthesizer
`default_nettype none

package esn_pkg;

  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned DEN_W      = 16;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] C1      = 32'd1686629713;
  localparam logic [31:0] C3      = 32'd693598668;
  localparam logic [31:0] C5      = 32'd85569304;
  localparam logic [31:0] C7      = 32'd5026995;
  localparam logic [31:0] C9      = 32'd172272;

  typedef enum logic [1:0] {
    STAGE_IDLE = 2'd0,
    STAGE_NOTE = 2'd1,
    STAGE_GAP  = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    CFG_ATTACK    = 2'd0,
    CFG_RELEASE   = 2'd1,
    CFG_GAP       = 2'd2,
    CFG_AMPLITUDE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } act_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_SQR,
    SEQ_SQR_W,
    SEQ_HMUL,
    SEQ_HSUB,
    SEQ_LMUL,
    SEQ_MAG,
    SEQ_AMP,
    SEQ_ENV,
    SEQ_DIV,
    SEQ_DIVW,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Horner coefficients, innermost term first after C9
  function automatic logic [31:0] horner_coef(input logic [1:0] idx);
    logic [31:0] c;
    unique case (idx)
      2'd0: c = C7;
      2'd1: c = C5;
      2'd2: c = C3;
      2'd3: c = C1;
      default: c = C1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/enveloped_sine_note_synth.sv
// Top level of the enveloped sine note synthesizer
//
// Input stream: tuser[0] selects load (0) or sample tick (1); tdata carries
// the phase increment and the note length. A load returns nothing; a tick
// returns one sample on the output stream.
// Output stream: tdata is the signed sample, tuser flags note body and idle,
// tlast marks the final sample of note plus gap.
// A tick in the note body runs the shared multiplier sequence (polynomial
// sine, amplitude and envelope products), starts the bit-serial envelope
// divider, waits for it and then loads the output register; the next item
// is taken once the sequencer is back in SEQ_IDLE. Ticks in gap or idle go
// straight to the output register load.
// s_axis_tready is high only between items.
// A finished sample sits in the output register; the block accepts the next
// item while it waits, and holds a new sample until the register is free.
// The configuration channel is always ready. It is written between items by
// the user; the block does not enforce this. Reset restores the register
// defaults, idles the block and zeroes the phase accumulator and all counters.
`default_nettype none
`include "enveloped_sine_note_synth_macros.svh"

module enveloped_sine_note_synth
  import esn_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // phase_step[31:0], note_len[47:32]
  input  wire logic [0:0]  s_axis_tuser,   // action[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // sample[15:0]
  output logic      [1:0]  m_axis_tuser,   // in_note[0], idle[1]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] IDX_MASK = ~((32'd1 << (32 - IDX_W)) - 32'd1);
  localparam int unsigned LIMIT_RAW = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int unsigned LIMIT = (LIMIT_RAW > 32767) ? 32767 : LIMIT_RAW;
  localparam logic [15:0] SMP_LIMIT = 16'(LIMIT);

  logic [15:0] attack_q, release_q, gap_len_q;
  logic [14:0] amp_q;

  logic [31:0] phase_accum_q, phase_incr_q;
  logic [15:0] sample_index_q, note_length_q, gap_index_q;
  stage_e      stage_q;

  seq_e        seq_q, seq_d;
  logic [1:0]  hidx_q;

  logic [30:0] u_q;
  logic        neg_q;
  logic [15:0] num_q, den_q;
  logic [31:0] u2_q, s_q;
  logic [14:0] m_q;
  logic [15:0] smp_q;
  logic        pend_in_note_q, pend_idle_q, pend_end_q;

  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_last_q;

  logic              in_accept;
  logic              is_tick;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [DIVIDEND_W-1:0] quotient;
  div_stat_t         div_stat;

  logic [31:0] p_masked;
  logic [30:0] u_base, u_new;
  logic [15:0] num_new, den_new;
  logic [15:0] nidx, gidx;
  logic        tick_in_note, tick_idle, tick_end;

  logic [31:0] s_lin;
  logic [30:0] s_clamp, m_sum;
  logic [15:0] m_round;
  logic [15:0] mag;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (act_e'(s_axis_tuser[0]) == ACT_TICK);
  assign s_axis_tready = (seq_q == SEQ_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  esn_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  esn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[45:15]),
    .divisor_i  (den_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= 16'd240;
      release_q <= 16'd720;
      gap_len_q <= 16'd960;
      amp_q     <= 15'd27852;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ATTACK:    attack_q  <= cfg_data_i;
        CFG_RELEASE:   release_q <= cfg_data_i;
        CFG_GAP:       gap_len_q <= cfg_data_i;
        CFG_AMPLITUDE: amp_q     <= cfg_data_i[14:0];
        default:       amp_q     <= amp_q;
      endcase
    end
  end

  // table phase, folded into the first quadrant
  assign p_masked = phase_accum_q & IDX_MASK;
  assign u_base   = {1'b0, p_masked[29:0]};
  assign u_new    = p_masked[30] ? (Q30_ONE[30:0] - u_base) : u_base;

  always_comb begin
    num_new = 16'd1;
    den_new = 16'd1;
    priority if (sample_index_q < attack_q) begin
      num_new = sample_index_q;
      den_new = attack_q;
    end else if (({1'b0, sample_index_q} + {1'b0, release_q} >= {1'b0, note_length_q})
                 && (release_q != 16'd0)) begin
      num_new = (note_length_q > sample_index_q) ?
                (note_length_q - 16'd1 - sample_index_q) : 16'd0;
      den_new = (release_q > 16'd1) ? (release_q - 16'd1) : 16'd1;
    end else begin
      num_new = 16'd1;
      den_new = 16'd1;
    end
  end

  assign nidx = sample_index_q + 16'd1;
  assign gidx = gap_index_q + 16'd1;

  always_comb begin
    tick_in_note = 1'b0;
    tick_idle    = 1'b0;
    tick_end     = 1'b0;
    unique case (stage_q)
      STAGE_NOTE: begin
        tick_in_note = 1'b1;
        tick_end     = (nidx >= note_length_q) && (gap_len_q == 16'd0);
      end
      STAGE_GAP: begin
        tick_end = (gidx >= gap_len_q) || (gidx == 16'd0);
      end
      default: begin
        tick_idle = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_accum_q  <= '0;
      phase_incr_q   <= '0;
      sample_index_q <= '0;
      note_length_q  <= '0;
      gap_index_q    <= '0;
      stage_q        <= STAGE_IDLE;
    end else if (in_accept) begin
      if (!is_tick) begin
        phase_accum_q  <= '0;
        phase_incr_q   <= s_axis_tdata[31:0];
        note_length_q  <= s_axis_tdata[47:32];
        sample_index_q <= '0;
        gap_index_q    <= '0;
        if (s_axis_tdata[47:32] != 16'd0) begin
          stage_q <= STAGE_NOTE;
        end else if (gap_len_q != 16'd0) begin
          stage_q <= STAGE_GAP;
        end else begin
          stage_q <= STAGE_IDLE;
        end
      end else begin
        unique case (stage_q)
          STAGE_NOTE: begin
            phase_accum_q  <= phase_accum_q + phase_incr_q;
            sample_index_q <= nidx;
            if (nidx >= note_length_q) begin
              gap_index_q <= '0;
              stage_q     <= (gap_len_q != 16'd0) ? STAGE_GAP : STAGE_IDLE;
            end
          end
          STAGE_GAP: begin
            gap_index_q <= gidx;
            if ((gidx >= gap_len_q) || (gidx == 16'd0)) begin
              stage_q <= STAGE_IDLE;
            end
          end
          default: begin
            stage_q <= STAGE_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_accept && is_tick) begin
          seq_d = (stage_q == STAGE_NOTE) ? SEQ_SQR : SEQ_DONE;
        end
      end
      SEQ_SQR:   seq_d = SEQ_SQR_W;
      SEQ_SQR_W: seq_d = SEQ_HMUL;
      SEQ_HMUL:  seq_d = SEQ_HSUB;
      SEQ_HSUB:  seq_d = (hidx_q == 2'd3) ? SEQ_LMUL : SEQ_HMUL;
      SEQ_LMUL:  seq_d = SEQ_MAG;
      SEQ_MAG:   seq_d = SEQ_AMP;
      SEQ_AMP:   seq_d = SEQ_ENV;
      SEQ_ENV:   seq_d = SEQ_DIV;
      SEQ_DIV:   seq_d = SEQ_DIVW;
      SEQ_DIVW:  seq_d = div_stat.done ? SEQ_DONE : SEQ_DIVW;
      SEQ_DONE:  seq_d = out_free ? SEQ_IDLE : SEQ_DONE;
      default:   seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (seq_q)
      SEQ_SQR: begin
        mul_a = {1'b0, u_q};
        mul_b = {1'b0, u_q};
      end
      SEQ_HMUL: begin
        mul_a = s_q;
        mul_b = u2_q;
      end
      SEQ_LMUL: begin
        mul_a = s_q;
        mul_b = {1'b0, u_q};
      end
      SEQ_AMP: begin
        mul_a = {17'd0, m_q};
        mul_b = {17'd0, amp_q};
      end
      SEQ_ENV: begin
        mul_a = prod[31:0];
        mul_b = {16'd0, num_q};
      end
      SEQ_DIV: begin
        div_start = 1'b1;
      end
      SEQ_DONE: begin
        out_load = out_free;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      hidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SEQ_SQR_W) begin
        hidx_q <= '0;
      end else if (seq_q == SEQ_HSUB) begin
        hidx_q <= hidx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sine magnitude: clamp to one, round to 15 fractional bits
  assign s_lin   = prod[61:30];
  assign s_clamp = (s_lin > Q30_ONE) ? Q30_ONE[30:0] : s_lin[30:0];
  assign m_sum   = s_clamp + 31'd16384;
  assign m_round = m_sum[30:15];

  assign mag = (quotient > {15'd0, SMP_LIMIT}) ? SMP_LIMIT : quotient[15:0];

  always_ff @(posedge clk_i) begin
    if (in_accept && is_tick) begin
      u_q            <= u_new;
      neg_q          <= p_masked[31];
      num_q          <= num_new;
      den_q          <= den_new;
      smp_q          <= '0;
      pend_in_note_q <= tick_in_note;
      pend_idle_q    <= tick_idle;
      pend_end_q     <= tick_end;
    end
    unique case (seq_q)
      SEQ_SQR_W: begin
        u2_q <= prod[61:30];
        s_q  <= C9;
      end
      SEQ_HSUB: begin
        s_q <= horner_coef(hidx_q) - prod[61:30];
      end
      SEQ_MAG: begin
        m_q <= (m_round > 16'd32767) ? 15'd32767 : m_round[14:0];
      end
      SEQ_DIVW: begin
        if (div_stat.done) begin
          smp_q <= neg_q ? (~mag + 16'd1) : mag;
        end
      end
      default: begin
        s_q <= s_q;
      end
    endcase
    if (out_load) begin
      out_data_q <= smp_q;
      out_user_q <= {pend_idle_q, pend_in_note_q};
      out_last_q <= pend_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  `ESN_ASSERT(a_load_no_result,
    (in_accept && !is_tick && !m_axis_tvalid) |=> !m_axis_tvalid, "load produced a sample")
  `ESN_ASSERT(a_silent_zero,
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0), "nonzero silent sample")
  `ESN_NEVER(a_idle_flags,
    m_axis_tvalid && m_axis_tuser[1] && (m_axis_tuser[0] || m_axis_tlast), "idle flag conflict")
  `ESN_ASSERT(a_div_busy_blocks,
    div_start |=> (div_stat.busy && !s_axis_tready), "input taken during divide")

endmodule

`default_nettype wire

### hdl/esn_mul.sv
// Shared 32x32 unsigned multiplier with registered product
`default_nettype none

module esn_mul
  import esn_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [MUL_W-1:0]  a_i,
  input  wire logic [MUL_W-1:0]  b_i,
  output logic      [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### hdl/esn_div.sv
// Bit-serial restoring divider for the envelope fraction
`default_nettype none

module esn_div
  import esn_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0]      divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output div_stat_t                  stat_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic [DEN_W-1:0]      dvs_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DEN_W:0]        shifted;
  logic [DEN_W:0]        diff;
  logic                  fits;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire
